// File: rtl/psev_pkg.sv
`default_nettype none

package psev_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int PTR_W       = $clog2(STACK_DEPTH);
  localparam int DATA_W      = 32;
  localparam int OP_W        = 3;
  localparam int DEPTH_W     = 7;
  localparam int STATUS_W    = 2;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int DIV_CNT_W   = $clog2(DATA_W);

  localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
  localparam logic [OP_W-1:0] OP_ADD  = 3'd1;
  localparam logic [OP_W-1:0] OP_SUB  = 3'd2;
  localparam logic [OP_W-1:0] OP_MUL  = 3'd3;
  localparam logic [OP_W-1:0] OP_DIV  = 3'd4;
  localparam logic [OP_W-1:0] OP_MOD  = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_UNDER   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER    = 2'd2;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 2'd3;

  typedef logic [1:0] kind_t;

  localparam kind_t K_PUSH = 2'd0;
  localparam kind_t K_ALU  = 2'd1;
  localparam kind_t K_DIV  = 2'd2;
  localparam kind_t K_NOP  = 2'd3;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    kind_t           kind;
    data_t           push_value;
  } entry_t;

  typedef struct packed {
    logic  done;
    data_t quotient;
    data_t remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

// File: rtl/psev_if.sv
`default_nettype none

interface psev_tok_if;
  import psev_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [OP_W-1:0]        op;
  logic signed [DATA_W-1:0] push_value;

  modport source (output valid, output op, output push_value, input ready);
  modport sink (input valid, input op, input push_value, output ready);
endinterface

interface psev_res_if;
  import psev_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] top_value;
  logic [DEPTH_W-1:0]       depth;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, output top_value, output depth, output status, input ready);
  modport sink (input valid, input top_value, input depth, input status, output ready);
endinterface

`default_nettype wire

// File: rtl/psev_div.sv
`default_nettype none

module psev_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  psev_pkg::data_t   dividend,
  input  psev_pkg::data_t   divisor,
  output psev_pkg::div_rsp_t rsp
);
  import psev_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] step_r;
  logic [DATA_W-1:0]    rem_r;
  logic [DATA_W-1:0]    quo_r;
  logic [DATA_W-1:0]    dvs_r;
  logic                 neg_q_r;
  logic                 neg_r_r;
  logic [DATA_W:0]      rem_sh;
  logic [DATA_W:0]      diff;

  assign rem_sh = {rem_r, quo_r[DATA_W-1]};
  assign diff   = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + DIV_CNT_W'(1);
        if (step_r == DIV_CNT_W'(DATA_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Magnitudes are divided; signs are restored on the way out.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r   <= '0;
      quo_r   <= dividend[DATA_W-1] ? DATA_W'(-dividend) : DATA_W'(dividend);
      dvs_r   <= divisor[DATA_W-1] ? DATA_W'(-divisor) : DATA_W'(divisor);
      neg_q_r <= dividend[DATA_W-1] ^ divisor[DATA_W-1];
      neg_r_r <= dividend[DATA_W-1];
    end else if (busy_r) begin
      if (!diff[DATA_W]) begin
        rem_r <= diff[DATA_W-1:0];
      end else begin
        rem_r <= rem_sh[DATA_W-1:0];
      end
      quo_r <= {quo_r[DATA_W-2:0], ~diff[DATA_W]};
    end
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = neg_q_r ? data_t'(-quo_r) : data_t'(quo_r);
  assign rsp.remainder = neg_r_r ? data_t'(-rem_r) : data_t'(rem_r);

endmodule

`default_nettype wire

// File: rtl/psev_front.sv
`default_nettype none

module psev_front (
  input  logic             clk,
  input  logic             rst_n,
  psev_tok_if.sink         in_tok,
  output logic             q_valid,
  output psev_pkg::entry_t q_entry,
  input  logic             q_pop
);
  import psev_pkg::*;

  entry_t              fifo_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;
  logic                wr_en;
  logic                rd_en;
  entry_t              new_entry;

  assign in_tok.ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign wr_en        = in_tok.valid && in_tok.ready;
  assign q_valid      = (cnt_r != '0);
  assign rd_en        = q_pop && q_valid;
  assign q_entry      = fifo_r[rd_ptr_r];

  always_comb begin
    new_entry.op         = in_tok.op;
    new_entry.push_value = in_tok.push_value;
    case (in_tok.op)
      OP_PUSH: new_entry.kind = K_PUSH;
      OP_ADD:  new_entry.kind = K_ALU;
      OP_SUB:  new_entry.kind = K_ALU;
      OP_MUL:  new_entry.kind = K_ALU;
      OP_DIV:  new_entry.kind = K_DIV;
      OP_MOD:  new_entry.kind = K_DIV;
      default: new_entry.kind = K_NOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fifo_r[wr_ptr_r] <= new_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
      end
      if (wr_en && !rd_en) begin
        cnt_r <= cnt_r + QCNT_W'(1);
      end else if (rd_en && !wr_en) begin
        cnt_r <= cnt_r - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

// File: rtl/psev_back.sv
`default_nettype none

module psev_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             q_valid,
  input  psev_pkg::entry_t q_entry,
  output logic             q_pop,
  psev_res_if.source       out_res
);
  import psev_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_FILL = 2'd2;

  // The two top entries live in registers; the memory holds the rest.
  data_t               mem [STACK_DEPTH];
  data_t               rd_data_r;
  logic [PTR_W-1:0]    rd_addr;
  logic [PTR_W-1:0]    wr_addr;
  logic                mem_we;

  logic [1:0]          state_r;
  logic [1:0]          state_nxt;
  data_t               top_r;
  data_t               top_nxt;
  data_t               nos_r;
  data_t               nos_nxt;
  logic [CNT_W-1:0]    cnt_r;
  logic [CNT_W-1:0]    cnt_nxt;
  logic                mod_r;

  logic                out_valid_r;
  data_t               out_top_r;
  logic [DEPTH_W-1:0]  out_depth_r;
  logic [STATUS_W-1:0] out_status_r;

  logic                out_free;
  logic                emit;
  logic [STATUS_W-1:0] emit_status;
  logic                div_start;
  div_rsp_t            div_rsp;
  data_t               alu_res;

  psev_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (nos_r),
    .divisor  (top_r),
    .rsp      (div_rsp)
  );

  assign out_free = !out_valid_r || out_res.ready;
  assign wr_addr  = PTR_W'(cnt_r - CNT_W'(2));
  assign rd_addr  = PTR_W'(cnt_r - CNT_W'(3));

  always_comb begin
    case (q_entry.op)
      OP_ADD:  alu_res = nos_r + top_r;
      OP_SUB:  alu_res = nos_r - top_r;
      default: alu_res = nos_r * top_r;
    endcase
  end

  always_comb begin
    state_nxt   = state_r;
    top_nxt     = top_r;
    nos_nxt     = nos_r;
    cnt_nxt     = cnt_r;
    mem_we      = 1'b0;
    emit        = 1'b0;
    emit_status = ST_OK;
    q_pop       = 1'b0;
    div_start   = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (q_valid && out_free) begin
          q_pop = 1'b1;
          emit  = 1'b1;
          case (q_entry.kind)
            K_PUSH: begin
              if (cnt_r == CNT_W'(STACK_DEPTH)) begin
                emit_status = ST_OVER;
              end else begin
                mem_we  = (cnt_r >= CNT_W'(2));
                nos_nxt = top_r;
                top_nxt = q_entry.push_value;
                cnt_nxt = cnt_r + CNT_W'(1);
              end
            end
            K_ALU: begin
              if (cnt_r < CNT_W'(2)) begin
                emit_status = ST_UNDER;
              end else begin
                top_nxt = alu_res;
                cnt_nxt = cnt_r - CNT_W'(1);
                if (cnt_r >= CNT_W'(3)) begin
                  state_nxt = S_FILL;
                end
              end
            end
            K_DIV: begin
              if (cnt_r < CNT_W'(2)) begin
                emit_status = ST_UNDER;
              end else if (top_r == '0) begin
                emit_status = ST_DIVZERO;
              end else begin
                emit      = 1'b0;
                div_start = 1'b1;
                state_nxt = S_DIV;
              end
            end
            default: begin
              emit_status = ST_OK;
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_rsp.done) begin
          emit    = 1'b1;
          top_nxt = mod_r ? div_rsp.remainder : div_rsp.quotient;
          cnt_nxt = cnt_r - CNT_W'(1);
          state_nxt = (cnt_r >= CNT_W'(3)) ? S_FILL : S_IDLE;
        end
      end
      S_FILL: begin
        nos_nxt   = rd_data_r;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= nos_r;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    top_r <= top_nxt;
    nos_r <= nos_nxt;
    if (div_start) begin
      mod_r <= (q_entry.op == OP_MOD);
    end
    if (emit) begin
      out_top_r    <= (cnt_nxt != '0) ? top_nxt : '0;
      out_depth_r  <= DEPTH_W'(cnt_nxt);
      out_status_r <= emit_status;
    end
  end

  assign out_res.valid     = out_valid_r;
  assign out_res.top_value = out_top_r;
  assign out_res.depth     = out_depth_r;
  assign out_res.status    = out_status_r;

endmodule

`default_nettype wire

// File: rtl/postfix_stack_evaluator.sv
`default_nettype none
// Push, add, subtract, multiply, ignored and rejected tokens give their result beat
// through the token queue and the result register; divide and modulo wait for the divider.
// Throughput is one token per cycle while results are taken; divide and modulo hold the
// execution side until the divider finishes, and a pop from a stack of three or more
// entries adds a refill state. Reset is synchronous and active low; it empties the stack
// and token queue; the operand memory keeps its contents and needs no clearing pass.

module postfix_stack_evaluator (
  input logic        clk,
  input logic        rst_n,
  psev_tok_if.sink   in_tok,
  psev_res_if.source out_res
);
  import psev_pkg::*;

  logic   q_valid;
  logic   q_pop;
  entry_t q_entry;

  psev_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_tok  (in_tok),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop)
  );

  psev_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_entry (q_entry),
    .q_pop   (q_pop),
    .out_res (out_res)
  );

endmodule

`default_nettype wire

// File: rtl/psev_chk.sv
`default_nettype none

module psev_chk (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic signed [psev_pkg::DATA_W-1:0] out_top_value,
  input logic [psev_pkg::DEPTH_W-1:0]  out_depth,
  input logic [psev_pkg::STATUS_W-1:0] out_status
);
  import psev_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result beat withdrawn");

  a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_depth == '0 |-> out_top_value == '0)
    else $error("empty stack reports a nonzero top");

  a_under: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_UNDER |-> out_depth < DEPTH_W'(2))
    else $error("underflow reported with two or more entries");

  a_over: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OVER |-> out_depth == DEPTH_W'(STACK_DEPTH))
    else $error("overflow reported on a stack that is not full");

endmodule

bind postfix_stack_evaluator psev_chk u_psev_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_res.valid),
  .out_ready     (out_res.ready),
  .out_top_value (out_res.top_value),
  .out_depth     (out_res.depth),
  .out_status    (out_res.status)
);

`default_nettype wire
